/* rtl/dtu_pkg.sv */
// ----------------------------------------------------------------------------
// dtu_pkg
// Shared types, constants and the suffix table for the duration text parser.
// ----------------------------------------------------------------------------
package dtu_pkg;

	typedef enum logic [1:0] {
		UNIT_MS  = 2'd0,
		UNIT_SEC = 2'd1,
		UNIT_MIN = 2'd2,
		UNIT_BAD = 2'd3
	} unit_t;

	localparam logic [15:0] MS_PER_SEC  = 16'd1000;
	localparam logic [15:0] MS_PER_MIN  = 16'd60000;
	localparam logic [15:0] SEC_PER_MIN = 16'd60;
	localparam logic [4:0]  MAX_DIGIT_POS = 5'd21;
	localparam int unsigned HASH_MOD = 36;

	localparam logic [63:0] U64_MAX = '1;

	// values once the count has saturated at all ones
	localparam logic [63:0] SAT_SEC_FROM_MS  = U64_MAX / 64'(MS_PER_SEC);
	localparam logic [63:0] SAT_MIN_FROM_MS  = U64_MAX / 64'(MS_PER_MIN);
	localparam logic [63:0] SAT_MIN_FROM_SEC = U64_MAX / 64'(SEC_PER_MIN);
	localparam logic [63:0] SAT_MS_FROM_SEC  = 64'd0 - 64'(MS_PER_SEC);
	localparam logic [63:0] SAT_MS_FROM_MIN  = 64'd0 - 64'(MS_PER_MIN);
	localparam logic [63:0] SAT_SEC_FROM_MIN = 64'd0 - 64'(SEC_PER_MIN);
	localparam logic [9:0]  SAT_REM_MS1000   = 10'(U64_MAX % 64'(MS_PER_SEC));
	localparam logic [15:0] SAT_REM_MS60000  = 16'(U64_MAX % 64'(MS_PER_MIN));
	localparam logic [5:0]  SAT_REM_SEC60    = 6'(U64_MAX % 64'(SEC_PER_MIN));

	localparam unit_t UNIT_TABLE [32] = '{
		UNIT_MIN, UNIT_MIN, UNIT_BAD, UNIT_BAD, UNIT_BAD, UNIT_BAD, UNIT_BAD, UNIT_SEC,
		UNIT_MS,  UNIT_BAD, UNIT_MIN, UNIT_BAD, UNIT_BAD, UNIT_BAD, UNIT_BAD, UNIT_BAD,
		UNIT_BAD, UNIT_MIN, UNIT_BAD, UNIT_MS,  UNIT_BAD, UNIT_BAD, UNIT_BAD, UNIT_BAD,
		UNIT_SEC, UNIT_BAD, UNIT_MS,  UNIT_SEC, UNIT_BAD, UNIT_BAD, UNIT_BAD, UNIT_SEC
	};

	// one byte moving from the input register into the accumulator
	typedef struct packed {
		logic       step;
		logic       last;
		logic [7:0] text_byte;
	} byte_cmd_t;

	// running text state; count is also kept pre-converted into every unit
	typedef struct packed {
		logic [63:0] count;
		logic [63:0] sec_from_ms;
		logic [63:0] min_from_ms;
		logic [63:0] min_from_sec;
		logic [63:0] ms_from_sec;
		logic [63:0] ms_from_min;
		logic [63:0] sec_from_min;
		logic [9:0]  rem_ms1000;
		logic [15:0] rem_ms60000;
		logic [5:0]  rem_sec60;
		logic        digits_closed;
		logic        letter_seen;
		logic [5:0]  suffix_hash;
		logic [5:0]  whole_hash;
		logic [4:0]  byte_pos;
	} acc_t;

endpackage

/* rtl/dtu_accum.sv */
// ----------------------------------------------------------------------------
// dtu_accum
// Per-byte state update: digit count, unit conversions kept incrementally,
// suffix and whole-text hashes.
// ----------------------------------------------------------------------------
module dtu_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  dtu_pkg::byte_cmd_t cmd,
	output dtu_pkg::acc_t      upd
);

	dtu_pkg::acc_t acc_q;

	function automatic logic [63:0] times10(logic [63:0] x);
		return (x << 3) + (x << 1);
	endfunction

	function automatic logic [19:0] scale_digit(logic [3:0] d, logic [15:0] k);
		return 20'(d) * 20'(k);
	endfunction

	// floor(v / k) for v < 10k
	function automatic logic [3:0] quot_digit(logic [19:0] v, logic [15:0] k);
		logic [3:0] q;
		q = '0;
		for (int j = 1; j <= 9; j++) begin
			if (v >= 20'(j) * 20'(k))
				q = q + 4'd1;
		end
		return q;
	endfunction

	function automatic logic [5:0] add_mod36(logic [5:0] h, logic [7:0] c);
		logic [8:0] v;
		logic [6:0] s;
		v = {1'b0, c};
		if (v >= 9'(4 * dtu_pkg::HASH_MOD)) v = v - 9'(4 * dtu_pkg::HASH_MOD);
		if (v >= 9'(2 * dtu_pkg::HASH_MOD)) v = v - 9'(2 * dtu_pkg::HASH_MOD);
		if (v >= 9'(dtu_pkg::HASH_MOD))     v = v - 9'(dtu_pkg::HASH_MOD);
		s = 7'(v) + {1'b0, h};
		if (s >= 7'(dtu_pkg::HASH_MOD))     s = s - 7'(dtu_pkg::HASH_MOD);
		return s[5:0];
	endfunction

	logic        is_digit;
	logic        is_upper;
	logic        is_lower;
	logic [3:0]  dval;
	logic [7:0]  lb;
	logic [67:0] ten_c;
	logic        sat;
	logic [19:0] v1000;
	logic [19:0] v60000;
	logic [19:0] v60;
	logic [3:0]  q1000;
	logic [3:0]  q60000;
	logic [3:0]  q60;

	always_comb begin
		is_digit = (cmd.text_byte >= 8'h30) && (cmd.text_byte <= 8'h39);
		is_upper = (cmd.text_byte >= 8'h41) && (cmd.text_byte <= 8'h5A);
		is_lower = (cmd.text_byte >= 8'h61) && (cmd.text_byte <= 8'h7A);
		dval     = cmd.text_byte[3:0];
		lb       = is_upper ? cmd.text_byte + 8'd32 : cmd.text_byte;

		ten_c = ({4'b0, acc_q.count} << 3) + ({4'b0, acc_q.count} << 1) + 68'(dval);
		sat   = |ten_c[67:64];

		v1000  = 20'(acc_q.rem_ms1000) * 20'd10 + 20'(dval);
		v60000 = 20'(acc_q.rem_ms60000) * 20'd10 + 20'(dval);
		v60    = 20'(acc_q.rem_sec60) * 20'd10 + 20'(dval);
		q1000  = quot_digit(v1000, dtu_pkg::MS_PER_SEC);
		q60000 = quot_digit(v60000, dtu_pkg::MS_PER_MIN);
		q60    = quot_digit(v60, dtu_pkg::SEC_PER_MIN);

		upd = acc_q;
		if (!acc_q.digits_closed) begin
			if (is_digit && (acc_q.byte_pos < dtu_pkg::MAX_DIGIT_POS)) begin
				if (sat) begin
					upd.count        = dtu_pkg::U64_MAX;
					upd.sec_from_ms  = dtu_pkg::SAT_SEC_FROM_MS;
					upd.min_from_ms  = dtu_pkg::SAT_MIN_FROM_MS;
					upd.min_from_sec = dtu_pkg::SAT_MIN_FROM_SEC;
					upd.ms_from_sec  = dtu_pkg::SAT_MS_FROM_SEC;
					upd.ms_from_min  = dtu_pkg::SAT_MS_FROM_MIN;
					upd.sec_from_min = dtu_pkg::SAT_SEC_FROM_MIN;
					upd.rem_ms1000   = dtu_pkg::SAT_REM_MS1000;
					upd.rem_ms60000  = dtu_pkg::SAT_REM_MS60000;
					upd.rem_sec60    = dtu_pkg::SAT_REM_SEC60;
				end else begin
					upd.count        = ten_c[63:0];
					upd.sec_from_ms  = times10(acc_q.sec_from_ms) + 64'(q1000);
					upd.min_from_ms  = times10(acc_q.min_from_ms) + 64'(q60000);
					upd.min_from_sec = times10(acc_q.min_from_sec) + 64'(q60);
					upd.ms_from_sec  = times10(acc_q.ms_from_sec)
						+ 64'(scale_digit(dval, dtu_pkg::MS_PER_SEC));
					upd.ms_from_min  = times10(acc_q.ms_from_min)
						+ 64'(scale_digit(dval, dtu_pkg::MS_PER_MIN));
					upd.sec_from_min = times10(acc_q.sec_from_min)
						+ 64'(scale_digit(dval, dtu_pkg::SEC_PER_MIN));
					upd.rem_ms1000   = 10'(v1000 - scale_digit(q1000, dtu_pkg::MS_PER_SEC));
					upd.rem_ms60000  = 16'(v60000 - scale_digit(q60000, dtu_pkg::MS_PER_MIN));
					upd.rem_sec60    = 6'(v60 - scale_digit(q60, dtu_pkg::SEC_PER_MIN));
				end
			end else begin
				upd.digits_closed = 1'b1;
			end
		end
		if (acc_q.byte_pos < dtu_pkg::MAX_DIGIT_POS)
			upd.byte_pos = acc_q.byte_pos + 5'd1;

		if (is_upper || is_lower)
			upd.letter_seen = 1'b1;
		if (upd.letter_seen)
			upd.suffix_hash = add_mod36(acc_q.suffix_hash, lb);
		upd.whole_hash = add_mod36(acc_q.whole_hash, lb);
	end

	// state returns to zero after the last byte of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.step) begin
			acc_q <= cmd.last ? '0 : upd;
		end
	end

endmodule

/* rtl/dtu_result.sv */
// ----------------------------------------------------------------------------
// dtu_result
// Suffix lookup, unit selection and the result register.
// ----------------------------------------------------------------------------
module dtu_result (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dtu_pkg::acc_t       upd,
	input  dtu_pkg::unit_t      unit,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [63:0]         duration,
	output logic                bad_suffix
);

	logic [5:0]     hash;
	dtu_pkg::unit_t from;
	logic [63:0]    conv;
	logic           out_valid_q;
	logic [63:0]    duration_q;
	logic           bad_q;

	always_comb begin
		hash = upd.letter_seen ? upd.suffix_hash : upd.whole_hash;
		// hash 32..35 has no table entry
		from = hash[5] ? dtu_pkg::UNIT_BAD : dtu_pkg::UNIT_TABLE[hash[4:0]];
		conv = 64'd1;
		unique case (unit)
			dtu_pkg::UNIT_MS: begin
				unique case (from)
					dtu_pkg::UNIT_MS:  conv = upd.count;
					dtu_pkg::UNIT_SEC: conv = upd.ms_from_sec;
					dtu_pkg::UNIT_MIN: conv = upd.ms_from_min;
					dtu_pkg::UNIT_BAD: conv = 64'd1;
				endcase
			end
			dtu_pkg::UNIT_SEC: begin
				unique case (from)
					dtu_pkg::UNIT_MS:  conv = upd.sec_from_ms;
					dtu_pkg::UNIT_SEC: conv = upd.count;
					dtu_pkg::UNIT_MIN: conv = upd.sec_from_min;
					dtu_pkg::UNIT_BAD: conv = 64'd1;
				endcase
			end
			dtu_pkg::UNIT_MIN: begin
				unique case (from)
					dtu_pkg::UNIT_MS:  conv = upd.min_from_ms;
					dtu_pkg::UNIT_SEC: conv = upd.min_from_sec;
					dtu_pkg::UNIT_MIN: conv = upd.count;
					dtu_pkg::UNIT_BAD: conv = 64'd1;
				endcase
			end
			dtu_pkg::UNIT_BAD: conv = 64'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			duration_q <= conv;
			bad_q      <= (from == dtu_pkg::UNIT_BAD);
		end
	end

	assign out_valid  = out_valid_q;
	assign duration   = duration_q;
	assign bad_suffix = bad_q;

endmodule

/* rtl/duration_text_to_units.sv */
// ----------------------------------------------------------------------------
// duration_text_to_units
// Parses a duration text byte by byte and returns it in the configured unit.
// ----------------------------------------------------------------------------
//  channel  signals                                  transfer
//  cfg      cfg_valid cfg_ready output_unit           unit register write
//  in       in_valid in_ready text_byte final_byte    one text byte
//  out      out_valid out_ready duration bad_suffix   one result per text
//
// One byte per cycle. From input transfer to result a byte passes through the
// input register, then state update and unit select into the result register.
// Conversions are kept incrementally per digit, so no divider is needed.
// A final byte waits in the input register while the result register is held;
// other bytes never stall. Reset clears all text state and sets unit to ms.
// ----------------------------------------------------------------------------
module duration_text_to_units (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  output_unit,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] duration,
	output logic        bad_suffix
);

	dtu_pkg::unit_t     unit_q;
	logic               valid_s1;
	logic [7:0]         text_byte_s1;
	logic               final_byte_s1;
	logic               res_free;
	logic               advance;
	dtu_pkg::byte_cmd_t cmd;
	dtu_pkg::acc_t      upd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= dtu_pkg::UNIT_MS;
		end else if (cfg_valid) begin
			unit_q <= dtu_pkg::unit_t'(output_unit);
		end
	end

	assign res_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!final_byte_s1 || res_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_byte_s1  <= text_byte;
			final_byte_s1 <= final_byte;
		end
	end

	always_comb begin
		cmd.step      = advance;
		cmd.last      = final_byte_s1;
		cmd.text_byte = text_byte_s1;
	end

	dtu_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.upd    (upd)
	);

	dtu_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && final_byte_s1),
		.upd        (upd),
		.unit       (unit_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.duration   (duration),
		.bad_suffix (bad_suffix)
	);

endmodule

/* rtl/dtu_checker.sv */
// ----------------------------------------------------------------------------
// dtu_checker
// Port-level checks for the duration text parser, bound to the top level.
// ----------------------------------------------------------------------------
module dtu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] duration,
	input logic        bad_suffix
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duration) && $stable(bad_suffix))
		else $error("result changed while stalled");

	// bad suffix always reports duration 1
	a_bad_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_suffix |-> duration == 64'd1)
		else $error("bad suffix with duration other than 1");

	// input only backs up behind a held result
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// unit register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind duration_text_to_units dtu_checker u_dtu_checker (.*);

/* dv/duration_checker.sv */
// ----------------------------------------------------------------------------
// duration_checker
// Watches the unit, text and result channels of the duration parser. Predicts
// each result from the accepted bytes and compares it with what comes out.
// ----------------------------------------------------------------------------
module duration_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  output_unit,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] duration,
	input  logic        bad_suffix,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HASH_WRAP    = 36;
	localparam int unsigned DIGIT_WINDOW = 21;
	localparam logic [63:0] ALL_ONES     = '1;

	// hash of the suffix -> unit it names
	localparam dtu_pkg::unit_t SUFFIX_UNIT [32] = '{
		dtu_pkg::UNIT_MIN, dtu_pkg::UNIT_MIN, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD,
		dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_SEC,
		dtu_pkg::UNIT_MS,  dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_MIN, dtu_pkg::UNIT_BAD,
		dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD,
		dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_MIN, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_MS,
		dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD,
		dtu_pkg::UNIT_SEC, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_MS,  dtu_pkg::UNIT_SEC,
		dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_SEC
	};

	typedef struct packed {
		logic [63:0] dur;
		logic        bad;
	} parsed_t;

	parsed_t        parsed_q [$];
	parsed_t        want;
	dtu_pkg::unit_t unit_sel;
	dtu_pkg::unit_t src_unit;
	logic [63:0]    count;
	logic [71:0]    wide;
	logic [7:0]     low_byte;
	bit             digits_done;
	bit             letter_hit;
	bit             is_upper;
	bit             is_lower;
	bit             is_digit;
	int unsigned    suffix_sum;
	int unsigned    text_sum;
	int unsigned    char_pos;
	int unsigned    pick;

	initial fail_count = 0;

	task automatic report(string what, logic [63:0] got, logic [63:0] exp_val);
		$display("%0t ns: %s mismatch: got %0h, expected %0h", $realtime, what, got,
			exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_sel    = dtu_pkg::UNIT_MS;
			count       = '0;
			digits_done = 0;
			letter_hit  = 0;
			suffix_sum  = 0;
			text_sum    = 0;
			char_pos    = 0;
			parsed_q.delete();
			pending     = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				unit_sel = dtu_pkg::unit_t'(output_unit);

			if (in_valid && in_ready) begin
				is_upper = text_byte >= "A" && text_byte <= "Z";
				is_lower = text_byte >= "a" && text_byte <= "z";
				is_digit = text_byte >= "0" && text_byte <= "9";
				low_byte = is_upper ? text_byte + 8'd32 : text_byte;

				if (!digits_done) begin
					if (is_digit && char_pos < DIGIT_WINDOW) begin
						wide  = 72'(count) * 72'd10 + 72'(text_byte - 8'h30);
						count = (wide > 72'(ALL_ONES)) ? ALL_ONES : wide[63:0];
					end else begin
						digits_done = 1;
					end
				end
				if (char_pos < DIGIT_WINDOW)
					char_pos++;

				if (is_upper || is_lower)
					letter_hit = 1;
				if (letter_hit)
					suffix_sum = (suffix_sum + low_byte) % HASH_WRAP;
				text_sum = (text_sum + low_byte) % HASH_WRAP;

				if (final_byte) begin
					pick     = letter_hit ? suffix_sum : text_sum;
					src_unit = (pick < 32) ? SUFFIX_UNIT[pick] : dtu_pkg::UNIT_BAD;
					if (src_unit == dtu_pkg::UNIT_BAD) begin
						want.dur = 64'd1;
						want.bad = 1'b1;
					end else begin
						want.bad = 1'b0;
						case (unit_sel)
							dtu_pkg::UNIT_MS: begin
								case (src_unit)
									dtu_pkg::UNIT_MS:  want.dur = count;
									dtu_pkg::UNIT_SEC: want.dur = count * 64'd1000;
									default:           want.dur = count * 64'd60000;
								endcase
							end
							dtu_pkg::UNIT_SEC: begin
								case (src_unit)
									dtu_pkg::UNIT_MS:  want.dur = count / 64'd1000;
									dtu_pkg::UNIT_SEC: want.dur = count;
									default:           want.dur = count * 64'd60;
								endcase
							end
							dtu_pkg::UNIT_MIN: begin
								case (src_unit)
									dtu_pkg::UNIT_MS:  want.dur = count / 64'd60000;
									dtu_pkg::UNIT_SEC: want.dur = count / 64'd60;
									default:           want.dur = count;
								endcase
							end
							default: want.dur = 64'd1;
						endcase
					end
					parsed_q.push_back(want);
					count       = '0;
					digits_done = 0;
					letter_hit  = 0;
					suffix_sum  = 0;
					text_sum    = 0;
					char_pos    = 0;
				end
			end

			if (out_valid && out_ready) begin
				if (parsed_q.size() == 0) begin
					report("unexpected result duration", duration, '0);
				end else begin
					want = parsed_q.pop_front();
					if (duration !== want.dur)
						report("duration", duration, want.dur);
					if (bad_suffix !== want.bad)
						report("bad_suffix", 64'(bad_suffix), 64'(want.bad));
				end
			end
			pending = parsed_q.size();
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the duration parser testbench. Feeds directed and random duration
// texts under every output unit, with random idles on both channels, and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [1:0]  output_unit = 2'd0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte   = 8'd0;
	logic        final_byte  = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [63:0] duration;
	logic        bad_suffix;
	int          fail_count;
	int          pending;

	bit          no_idle     = 1'b0;
	logic [7:0]  text_q [$];
	int          bytes_sent  = 0;

	localparam int    PHASE_BYTES = 65;
	localparam dtu_pkg::unit_t UNIT_PLAN [7] = '{
		dtu_pkg::UNIT_MIN, dtu_pkg::UNIT_SEC, dtu_pkg::UNIT_BAD, dtu_pkg::UNIT_MS,
		dtu_pkg::UNIT_MIN, dtu_pkg::UNIT_SEC, dtu_pkg::UNIT_MS
	};
	localparam string SUFFIX_WORDS [14] = '{
		"ms", "msec", "s", "sec", "secs", "second", "m", "min", "mins", "minute",
		"h", "hr", "d", "x"
	};

	duration_text_to_units DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.output_unit(output_unit),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duration   (duration),
		.bad_suffix (bad_suffix)
	);

	duration_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.output_unit(output_unit),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duration   (duration),
		.bad_suffix (bad_suffix),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	// result side: mostly ready, short stalls, now and then a long one
	initial begin
		int hold;
		int r;
		hold = 0;
		forever begin
			@(posedge clk);
			if (no_idle) begin
				out_ready <= 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_ready <= 1'b1;
					hold = $urandom_range(0, 8);
				end else if (r < 90) begin
					out_ready <= 1'b0;
					hold = $urandom_range(0, 3);
				end else begin
					out_ready <= 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	task automatic add_str(string s, bit mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1))
				c = c - 8'd32;
			text_q.push_back(c);
		end
	endtask

	// valid stays up across back-to-back transfers; caller drops it at phase end
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		int r;
		in_valid   <= 1'b1;
		text_byte  <= b;
		final_byte <= last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		r = $urandom_range(0, 99);
		if (no_idle || r < 65)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic drain();
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_unit(dtu_pkg::unit_t u);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid   <= 1'b1;
		output_unit <= u;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly number + optional blanks + suffix word, some pure noise
	task automatic build_random_text();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			n = $urandom_range(1, 6);
			repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 10)
				n = 0;
			else if (r < 75)
				n = $urandom_range(1, 4);
			else if (r < 85)
				n = $urandom_range(5, 19);
			else
				n = 0;
			repeat (n) text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
			if (r >= 85 && r < 93)
				repeat ($urandom_range(19, 23)) text_q.push_back("9");
			else if (r >= 93 && r < 96)
				add_str("18446744073709551615", 0);
			else if (r >= 96)
				add_str("18446744073709551616", 0);

			r = $urandom_range(0, 99);
			if (r < 30)
				text_q.push_back(" ");
			else if (r < 35)
				add_str("  ", 0);

			if ($urandom_range(0, 99) < 60) begin
				add_str(SUFFIX_WORDS[$urandom_range(0, 13)], 1);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					if ($urandom_range(0, 1))
						text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
					else
						text_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
				end
			end

			// broken tail: a digit or a stray byte after the suffix
			r = $urandom_range(0, 99);
			if (r < 6)
				text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
			else if (r < 10)
				text_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_unit(dtu_pkg::UNIT_MS);

		add_str("250ms", 0);
		send_text();
		add_str("5 MIN", 0);
		send_text();
		add_str("3s", 0);
		send_text();
		// digits only: the whole text picks the entry
		add_str("42", 0);
		send_text();
		// zero byte inside the text
		text_q = '{8'h31, 8'h00, 8'h73};
		send_text();
		// high byte is not a letter
		text_q = '{8'hFF, 8'h68};
		send_text();
		// no number before the suffix
		add_str("Xy", 0);
		send_text();
		in_valid <= 1'b0;

		for (int p = 0; p < 7; p++) begin
			write_unit(UNIT_PLAN[p]);
			no_idle <= (p == 3);
			while (bytes_sent < 21 + (p + 1) * PHASE_BYTES) begin
				build_random_text();
				send_text();
			end
			in_valid <= 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
